[src/nbtm_pkg.sv]
// nbtm_pkg: shared types and codes for the neighbour table merge block
// holds the fsm state type, the token travelling down the cell chain, outcome
// and register codes; no dependencies
package nbtm_pkg;

    // fsm of the top level
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

    // control part of the token handed from cell to cell
    typedef struct packed {
        logic valid;       // token present at this cell
        logic search;      // look-up enabled for this transaction
        logic found;       // id seen in an earlier active slot
        logic improved;    // an earlier slot already took the lower hop count
        logic empty_seen;  // an earlier active slot is empty
    } token_t;

    // result outcome codes
    typedef logic [2:0] outcome_t;
    localparam outcome_t OUT_CLEARED  = 3'd0;
    localparam outcome_t OUT_INSERTED = 3'd1;
    localparam outcome_t OUT_IMPROVED = 3'd2;
    localparam outcome_t OUT_KEPT     = 3'd3;
    localparam outcome_t OUT_TOO_FAR  = 3'd4;
    localparam outcome_t OUT_FULL     = 3'd5;
    localparam outcome_t OUT_SKIPPED  = 3'd6;

    // configuration register indexes
    typedef logic [1:0] reg_idx_t;
    localparam reg_idx_t REG_ACTIVE_ENTRIES = 2'd0;
    localparam reg_idx_t REG_MAX_HOPS       = 2'd1;
    localparam reg_idx_t REG_OWN_NODE_ID    = 2'd2;

    // reset values of the configuration registers
    localparam logic [6:0] ACTIVE_ENTRIES_RESET = 7'd11;
    localparam logic [7:0] MAX_HOPS_RESET       = 8'd3;
    localparam logic [7:0] OWN_ID_RESET         = 8'd1;

endpackage

[src/nbtm_cell.sv]
// nbtm_cell: one slot of the neighbour table plus one stage of the search chain
// holds the slot id and hop count and registers the token towards its neighbour
// depends on nbtm_pkg
module nbtm_cell #(
    parameter int DEPTH = 64,
    parameter int K = 0,
    localparam int IDX_W = $clog2(DEPTH),
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               clear_i,
    input  logic [7:0]         own_id_i,
    input  logic               wr_en_i,
    input  logic [IDX_W-1:0]   wr_idx_i,
    input  logic [7:0]         wr_id_i,
    input  logic [7:0]         wr_hops_i,
    input  logic [CNT_W-1:0]   n_i,
    input  logic [7:0]         q_id_i,
    input  logic [7:0]         q_hops_i,
    input  nbtm_pkg::token_t   tok_i,
    input  logic [IDX_W-1:0]   hit_i,
    input  logic [IDX_W-1:0]   empty_i,
    input  logic [CNT_W-1:0]   cnt_i,
    output nbtm_pkg::token_t   tok_o,
    output logic [IDX_W-1:0]   hit_o,
    output logic [IDX_W-1:0]   empty_o,
    output logic [CNT_W-1:0]   cnt_o
);

    logic [7:0]       id_reg;
    logic [7:0]       hops_reg;
    nbtm_pkg::token_t tok_reg, tok_next;
    logic [IDX_W-1:0] hit_reg, hit_next;
    logic [IDX_W-1:0] empty_reg, empty_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic active;
    logic is_empty;
    logic match;
    logic improve;

    assign active   = CNT_W'(K) < n_i;
    assign is_empty = tok_i.valid && active && (id_reg == 8'd0);
    assign match    = tok_i.valid && tok_i.search && active && (id_reg == q_id_i);
    assign improve  = match && !tok_i.improved && (q_hops_i < hops_reg);

    always_comb begin
        tok_next            = tok_i;
        tok_next.found      = tok_i.found | match;
        tok_next.improved   = tok_i.improved | improve;
        tok_next.empty_seen = tok_i.empty_seen | is_empty;
        hit_next   = ((match && !tok_i.found) || improve) ? IDX_W'(K) : hit_i;
        empty_next = (is_empty && !tok_i.empty_seen) ? IDX_W'(K) : empty_i;
        cnt_next   = (tok_i.valid && active && (id_reg != 8'd0)) ?
                     cnt_i + CNT_W'(1) : cnt_i;
    end

    // slot storage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            id_reg   <= (K == 0) ? nbtm_pkg::OWN_ID_RESET : 8'd0;
            hops_reg <= 8'd0;
        end else if (clear_i) begin
            id_reg   <= (K == 0) ? own_id_i : 8'd0;
            hops_reg <= 8'd0;
        end else if (wr_en_i && (wr_idx_i == IDX_W'(K))) begin
            id_reg   <= wr_id_i;
            hops_reg <= wr_hops_i;
        end else if (improve) begin
            hops_reg <= q_hops_i;
        end
    end

    // token stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg <= '0;
        end else begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge aclk) begin
        hit_reg   <= hit_next;
        empty_reg <= empty_next;
        cnt_reg   <= cnt_next;
    end

    assign tok_o   = tok_reg;
    assign hit_o   = hit_reg;
    assign empty_o = empty_reg;
    assign cnt_o   = cnt_reg;

endmodule

[src/neighbor_table_merge.sv]
// neighbor_table_merge: top level of the neighbour table merge block
// configuration registers, control fsm, result register and a chain of
// nbtm_cell instances; depends on nbtm_pkg and nbtm_cell
//
// channel   direction  contents
// s_axis    in         tdata: entry_node_id, entry_hops; tuser: action; tlast: last_of_packet
// m_axis    out        tdata: outcome, slot_index, filled_count, all_found
// cfg       in         write only: cfg_we, cfg_addr, cfg_wdata
//
// after acceptance a result passes through the launch register, one token register per cell
// of the chain walk, the pending result register and the output register on its way to m_axis
// the next transaction is taken only once the fsm is back in idle, so transactions do not overlap;
// an insert is written as the token leaves the chain
// a waiting result holds in the output register while the next transaction is accepted,
// and a further result holds in the fsm until it is taken
// reset restores the table at once (slots are flip-flops), no clearing pass
module neighbor_table_merge #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input transactions
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] entry_node_id, [15:8] entry_hops
    input  logic [0:0]  s_axis_tuser,   // [0] action
    input  logic        s_axis_tlast,
    // result transactions
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [2:0] outcome, [8:3] slot_index,
                                        // [15:9] filled_count, [16] all_found
    // configuration writes
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [7:0]  cfg_wdata
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int N_W   = (CNT_W > 7) ? CNT_W : 7;   // common width for count compares
    localparam int S_W   = (IDX_W > 6) ? IDX_W : 6;   // common width for slot output

    // configuration
    logic [6:0] active_reg;
    logic [7:0] max_hops_reg;
    logic [7:0] own_id_reg;

    // control
    nbtm_pkg::state_t state_reg, state_next;
    logic             frozen_reg;
    logic             launch_reg;
    logic             accept;
    logic             load_out;

    // captured transaction
    logic [7:0] q_id_reg;
    logic [7:0] q_hops_reg;
    logic       q_last_reg;
    logic       q_clear_reg;
    logic       q_merge_reg;
    logic       q_search_reg;

    // pending result and output register
    nbtm_pkg::outcome_t res_outcome_reg;
    logic [5:0]         res_slot_reg;
    logic [6:0]         res_cnt_reg;
    logic               res_all_reg;
    logic               m_valid_reg;
    logic [23:0]        m_data_reg;

    // cell chain
    nbtm_pkg::token_t tok_chain   [TABLE_DEPTH+1];
    logic [IDX_W-1:0] hit_chain   [TABLE_DEPTH+1];
    logic [IDX_W-1:0] empty_chain [TABLE_DEPTH+1];
    logic [CNT_W-1:0] cnt_chain   [TABLE_DEPTH+1];

    logic [N_W-1:0]   active_ext;
    logic [CNT_W-1:0] n_active;
    logic             tail_valid;

    // decision at the end of the chain
    nbtm_pkg::outcome_t outcome_c;
    logic [IDX_W-1:0]   slot_c;
    logic [CNT_W-1:0]   cnt_c;
    logic               all_c;
    logic               freeze_c;
    logic               wr_en;
    logic [S_W-1:0]     slot_wide;
    logic [N_W-1:0]     cnt_wide;

    // active slot count saturates at the table depth
    assign active_ext = N_W'(active_reg);
    assign n_active   = (active_ext > N_W'(TABLE_DEPTH)) ?
                        CNT_W'(TABLE_DEPTH) : CNT_W'(active_ext);

    assign accept     = s_axis_tvalid && s_axis_tready;
    assign tail_valid = tok_chain[TABLE_DEPTH].valid;

    // configuration port
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg   <= nbtm_pkg::ACTIVE_ENTRIES_RESET;
            max_hops_reg <= nbtm_pkg::MAX_HOPS_RESET;
            own_id_reg   <= nbtm_pkg::OWN_ID_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                nbtm_pkg::REG_ACTIVE_ENTRIES: active_reg   <= cfg_wdata[6:0];
                nbtm_pkg::REG_MAX_HOPS:       max_hops_reg <= cfg_wdata;
                nbtm_pkg::REG_OWN_NODE_ID:    own_id_reg   <= cfg_wdata;
                default: ;  // index beyond the register list is dropped
            endcase
        end
    end

    // fsm next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            nbtm_pkg::ST_IDLE: if (accept) state_next = nbtm_pkg::ST_RUN;
            nbtm_pkg::ST_RUN:  if (tail_valid) state_next = nbtm_pkg::ST_DONE;
            nbtm_pkg::ST_DONE: if (load_out) state_next = nbtm_pkg::ST_IDLE;
            default:           state_next = nbtm_pkg::ST_IDLE;
        endcase
    end

    // fsm outputs
    always_comb begin
        s_axis_tready = 1'b0;
        load_out      = 1'b0;
        case (state_reg)
            nbtm_pkg::ST_IDLE: s_axis_tready = 1'b1;
            nbtm_pkg::ST_DONE: load_out = !m_valid_reg || m_axis_tready;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= nbtm_pkg::ST_IDLE;
            launch_reg <= 1'b0;
            frozen_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            launch_reg <= accept;
            if (accept && s_axis_tuser[0]) begin
                frozen_reg <= 1'b0;
            end else if (tail_valid && freeze_c) begin
                frozen_reg <= 1'b1;
            end
        end
    end

    // capture the transaction; merge and search are decided against the frozen mark now
    always_ff @(posedge aclk) begin
        if (accept) begin
            q_id_reg     <= s_axis_tdata[7:0];
            q_hops_reg   <= s_axis_tdata[15:8];
            q_last_reg   <= s_axis_tlast;
            q_clear_reg  <= s_axis_tuser[0];
            q_merge_reg  <= !s_axis_tuser[0] && !frozen_reg;
            q_search_reg <= !s_axis_tuser[0] && !frozen_reg &&
                            (s_axis_tdata[7:0] != 8'd0);
        end
    end

    // head of the chain: valid, search, then found, improved and empty_seen cleared
    assign tok_chain[0]   = {launch_reg, q_search_reg, 3'b000};
    assign hit_chain[0]   = '0;
    assign empty_chain[0] = '0;
    assign cnt_chain[0]   = '0;

    for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
        nbtm_cell #(
            .DEPTH (TABLE_DEPTH),
            .K     (k)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .clear_i   (accept && s_axis_tuser[0]),
            .own_id_i  (own_id_reg),
            .wr_en_i   (wr_en),
            .wr_idx_i  (empty_chain[TABLE_DEPTH]),
            .wr_id_i   (q_id_reg),
            .wr_hops_i (q_hops_reg),
            .n_i       (n_active),
            .q_id_i    (q_id_reg),
            .q_hops_i  (q_hops_reg),
            .tok_i     (tok_chain[k]),
            .hit_i     (hit_chain[k]),
            .empty_i   (empty_chain[k]),
            .cnt_i     (cnt_chain[k]),
            .tok_o     (tok_chain[k+1]),
            .hit_o     (hit_chain[k+1]),
            .empty_o   (empty_chain[k+1]),
            .cnt_o     (cnt_chain[k+1])
        );
    end

    // outcome once the token leaves the last cell
    always_comb begin
        outcome_c = nbtm_pkg::OUT_SKIPPED;
        slot_c    = '0;
        cnt_c     = cnt_chain[TABLE_DEPTH];
        wr_en     = 1'b0;
        if (q_clear_reg) begin
            outcome_c = nbtm_pkg::OUT_CLEARED;
        end else if (q_search_reg) begin
            if (tok_chain[TABLE_DEPTH].found) begin
                outcome_c = tok_chain[TABLE_DEPTH].improved ?
                            nbtm_pkg::OUT_IMPROVED : nbtm_pkg::OUT_KEPT;
                slot_c    = hit_chain[TABLE_DEPTH];
            end else if (q_hops_reg > max_hops_reg) begin
                outcome_c = nbtm_pkg::OUT_TOO_FAR;
            end else if (tok_chain[TABLE_DEPTH].empty_seen) begin
                outcome_c = nbtm_pkg::OUT_INSERTED;
                slot_c    = empty_chain[TABLE_DEPTH];
                cnt_c     = cnt_chain[TABLE_DEPTH] + CNT_W'(1);
                wr_en     = tail_valid;
            end else begin
                outcome_c = nbtm_pkg::OUT_FULL;
            end
        end
        all_c     = (cnt_c == n_active);
        // null ids still take part in the freeze check
        freeze_c  = q_merge_reg && q_last_reg && all_c;
        slot_wide = S_W'(slot_c);
        cnt_wide  = N_W'(cnt_c);
    end

    always_ff @(posedge aclk) begin
        if (tail_valid) begin
            res_outcome_reg <= outcome_c;
            res_slot_reg    <= slot_wide[5:0];
            res_cnt_reg     <= cnt_wide[6:0];
            res_all_reg     <= all_c;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_data_reg <= {7'd0, res_all_reg, res_cnt_reg, res_slot_reg, res_outcome_reg};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // no token may be in the chain while a new transaction can be taken
    a_idle_chain_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tready |-> !tail_valid)
        else $error("token in flight while ready");

    // the token only leaves the chain while the fsm waits for it
    a_tail_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        tail_valid |-> (state_reg == nbtm_pkg::ST_RUN))
        else $error("token left chain outside run state");

    // the frozen mark is only set when a token finishes its walk
    a_freeze_at_tail: assert property (@(posedge aclk) disable iff (!aresetn)
        (frozen_reg && !$past(frozen_reg)) |-> $past(tail_valid))
        else $error("frozen mark set without a finished walk");

    // an insert always leaves at least one filled slot
    a_insert_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && (m_axis_tdata[2:0] == nbtm_pkg::OUT_INSERTED))
        |-> (m_axis_tdata[15:9] != 7'd0))
        else $error("insert reported with empty table");

endmodule

[sim/tb.sv]
// tb: self-checking testbench for neighbor_table_merge, a clocked driver and monitor
// around the block with a built-in predictor of the neighbour table
// depends on nbtm_pkg and neighbor_table_merge from src
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH = 64;
    localparam int IDLE_PCT    = 24;    // percent of cycles either side sits idle
    localparam int HOLD_CYCLES = 400;   // one long receiver hold-off
    localparam int MAX_REPORTS = 10;

    // input action codes
    localparam logic ACT_MERGE = 1'b0;
    localparam logic ACT_CLEAR = 1'b1;
    // an index past the register list, writes there must be ignored
    localparam nbtm_pkg::reg_idx_t REG_SPARE = 2'd3;

    // one received entry as the sender offers it
    typedef struct packed {
        logic       action;
        logic [7:0] node_id;
        logic [7:0] hops;
        logic       last;
    } entry_t;

    // one result transaction, split into its fields
    typedef struct packed {
        nbtm_pkg::outcome_t outcome;
        logic [5:0]         slot;
        logic [6:0]         filled;
        logic               all_found;
    } merge_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;     // [7:0] entry_node_id, [15:8] entry_hops
    logic [0:0]  s_axis_tuser = '0;     // [0] action
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;          // [2:0] outcome, [8:3] slot_index,
                                        // [15:9] filled_count, [16] all_found
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [7:0]  cfg_wdata = '0;

    neighbor_table_merge #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    always #2 aclk = ~aclk;

    // entries waiting to be sent; the front one is on the bus while tvalid is high
    entry_t        pending_entries[$];
    // predicted results, oldest first
    merge_result_t expected_merges[$];

    // predictor copy of the table and the registers
    logic [7:0] nb_ids[TABLE_DEPTH];
    logic [7:0] nb_hops[TABLE_DEPTH];
    logic       table_frozen;
    logic [6:0] active_cfg;
    logic [7:0] hop_limit;
    logic [7:0] own_id;

    logic          entry_taken = 1'b0;
    logic          calm = 1'b0;         // no idling on either side while set
    logic          hold_req = 1'b0;
    logic          hold_used = 1'b0;
    int            hold_left = 0;
    int            mismatches = 0;
    int            results_seen = 0;
    merge_result_t want, got;

    // new round: empty table, own id in slot 0, frozen mark dropped
    function automatic void wipe_table();
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            nb_ids[k]  = 8'd0;
            nb_hops[k] = 8'd0;
        end
        nb_ids[0]    = own_id;
        table_frozen = 1'b0;
    endfunction

    function automatic int filled_slots(int span);
        int c;
        c = 0;
        for (int k = 0; k < span; k++)
            if (nb_ids[k] != 8'd0)
                c++;
        return c;
    endfunction

    // folds one entry into the predictor table and returns the result it causes
    function automatic merge_result_t merge_entry(entry_t e);
        merge_result_t r;
        int            span;
        int            hit;
        int            filled;
        bit            known;
        span = (active_cfg > TABLE_DEPTH) ? TABLE_DEPTH : int'(active_cfg);
        r.outcome = nbtm_pkg::OUT_SKIPPED;
        r.slot    = 6'd0;
        if (e.action == ACT_CLEAR) begin
            wipe_table();
            r.outcome = nbtm_pkg::OUT_CLEARED;
        end else if (!table_frozen) begin
            if (e.node_id != 8'd0) begin
                known = 1'b0;
                hit   = 0;
                // scan downwards so the first matching slot wins
                for (int k = span - 1; k >= 0; k--) begin
                    if (nb_ids[k] == e.node_id) begin
                        known = 1'b1;
                        hit   = k;
                    end
                end
                if (known) begin
                    r.outcome = nbtm_pkg::OUT_KEPT;
                    r.slot    = 6'(hit);
                    for (int k = 0; k < span; k++) begin
                        if (nb_ids[k] == e.node_id && e.hops < nb_hops[k]) begin
                            nb_hops[k] = e.hops;
                            r.outcome  = nbtm_pkg::OUT_IMPROVED;
                            r.slot     = 6'(k);
                            break;
                        end
                    end
                end else if (e.hops > hop_limit) begin
                    r.outcome = nbtm_pkg::OUT_TOO_FAR;
                end else begin
                    r.outcome = nbtm_pkg::OUT_FULL;
                    for (int k = 0; k < span; k++) begin
                        if (nb_ids[k] == 8'd0) begin
                            nb_ids[k]  = e.node_id;
                            nb_hops[k] = e.hops;
                            r.outcome  = nbtm_pkg::OUT_INSERTED;
                            r.slot     = 6'(k);
                            break;
                        end
                    end
                end
            end
            // null entries still close a packet and may freeze a full table
            if (e.last && filled_slots(span) == span)
                table_frozen = 1'b1;
        end
        filled      = filled_slots(span);
        r.filled    = 7'(filled);
        r.all_found = (filled == span);
        return r;
    endfunction

    // sender: a new transaction is put up only when the bus is free or was just taken
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || entry_taken) begin
            if (pending_entries.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {pending_entries[0].hops, pending_entries[0].node_id};
                s_axis_tuser  <= pending_entries[0].action;
                s_axis_tlast  <= pending_entries[0].last;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver: random stalls, plus one long hold-off that lets the block back up
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (hold_req && !hold_used) begin
            hold_used     <= 1'b1;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // accepted input transactions feed the predictor, accepted results are checked
    always @(posedge aclk) begin
        entry_taken <= s_axis_tvalid && s_axis_tready;
        if (s_axis_tvalid && s_axis_tready)
            expected_merges.push_back(merge_entry(pending_entries.pop_front()));
        if (m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (expected_merges.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("result %0d arrived with nothing expected: tdata %h",
                             results_seen, m_axis_tdata);
            end else begin
                want = expected_merges.pop_front();
                got  = {m_axis_tdata[2:0], m_axis_tdata[8:3], m_axis_tdata[15:9],
                        m_axis_tdata[16]};
                if (got.outcome !== want.outcome || got.slot !== want.slot ||
                    got.filled !== want.filled || got.all_found !== want.all_found) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("result %0d mismatch (expected/actual): outcome %0d/%0d slot %0d/%0d",
                                 results_seen, want.outcome, got.outcome, want.slot, got.slot);
                        $display("    filled %0d/%0d all_found %0b/%0b",
                                 want.filled, got.filled, want.all_found, got.all_found);
                    end
                end
            end
        end
    end

    function automatic void offer(logic act, logic [7:0] id, logic [7:0] hops, logic last);
        entry_t e;
        e = {act, id, hops, last};
        pending_entries.push_back(e);
    endfunction

    // block is idle once nothing waits to be sent and every result has come back
    task automatic wait_idle();
        while (pending_entries.size() != 0 || expected_merges.size() != 0)
            @(negedge aclk);
    endtask

    task automatic write_reg(nbtm_pkg::reg_idx_t idx, logic [7:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            nbtm_pkg::REG_ACTIVE_ENTRIES: active_cfg = val[6:0];
            nbtm_pkg::REG_MAX_HOPS:       hop_limit  = val;
            nbtm_pkg::REG_OWN_NODE_ID:    own_id     = val;
            default: ;
        endcase
    endtask

    task automatic set_config(logic [7:0] act, logic [7:0] hops, logic [7:0] own);
        wait_idle();
        write_reg(nbtm_pkg::REG_ACTIVE_ENTRIES, act);
        write_reg(nbtm_pkg::REG_MAX_HOPS, hops);
        write_reg(nbtm_pkg::REG_OWN_NODE_ID, own);
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // mostly well-formed entries drawn from a small id pool so that ids repeat,
    // with null ids, far-off ids and stray clears mixed in
    function automatic entry_t pick_neighbour(int base, int pool);
        entry_t e;
        int     roll;
        int     reach;
        roll     = $urandom_range(99);
        reach    = (int'(hop_limit) + 2 > 255) ? 255 : int'(hop_limit) + 2;
        e.action = ACT_MERGE;
        e.last   = 1'b0;
        if (roll < 2) begin
            e.action  = ACT_CLEAR;
            e.node_id = 8'($urandom);
            e.hops    = 8'($urandom);
        end else if (roll < 9) begin
            e.node_id = 8'd0;
            e.hops    = 8'($urandom);
        end else if (roll < 16) begin
            e.node_id = 8'($urandom);
            e.hops    = 8'($urandom);
        end else if (roll < 20) begin
            e.node_id = own_id;
            e.hops    = 8'($urandom_range(reach));
        end else begin
            e.node_id = 8'((base + $urandom_range(pool - 1)) % 255 + 1);
            e.hops    = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(reach));
        end
        return e;
    endfunction

    // rounds of one clear followed by packets of entries, until the budget is spent
    task automatic fill_rounds(int budget);
        entry_t e;
        int     span;
        int     made;
        int     base;
        int     round_left;
        int     pkt;
        span = (active_cfg > TABLE_DEPTH) ? TABLE_DEPTH : int'(active_cfg);
        made = 0;
        while (made < budget) begin
            offer(ACT_CLEAR, 8'($urandom), 8'($urandom), 1'($urandom));
            made++;
            base       = $urandom_range(254);
            round_left = $urandom_range(3 * span + 8, span + 2);
            while (round_left > 0 && made < budget) begin
                pkt = $urandom_range(8, 1);
                for (int k = 0; k < pkt; k++) begin
                    e      = pick_neighbour(base, span + 6);
                    e.last = (k == pkt - 1);
                    pending_entries.push_back(e);
                    made++;
                    round_left--;
                end
            end
        end
    endtask

    initial begin
        active_cfg = nbtm_pkg::ACTIVE_ENTRIES_RESET;
        hop_limit  = nbtm_pkg::MAX_HOPS_RESET;
        own_id     = nbtm_pkg::OWN_ID_RESET;
        wipe_table();
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings: null entry closing a packet, own id, insert, improve,
        // keep, over the hop limit, widest fields, clear with all data bits set
        offer(ACT_MERGE, 8'd0, 8'd0, 1'b1);
        offer(ACT_MERGE, 8'd1, 8'd5, 1'b0);
        offer(ACT_MERGE, 8'd7, 8'd3, 1'b0);
        offer(ACT_MERGE, 8'd7, 8'd2, 1'b0);
        offer(ACT_MERGE, 8'd7, 8'd2, 1'b0);
        offer(ACT_MERGE, 8'd200, 8'd4, 1'b0);
        offer(ACT_MERGE, 8'd255, 8'd0, 1'b0);
        offer(ACT_MERGE, 8'd9, 8'd255, 1'b0);
        offer(ACT_CLEAR, 8'd255, 8'd255, 1'b1);

        // two slots, no hop limit: table fills, freezes, merges are ignored
        wait_idle();
        write_reg(REG_SPARE, 8'hFF);
        set_config(8'd2, 8'd255, 8'd255);
        offer(ACT_CLEAR, 8'd0, 8'd0, 1'b0);
        offer(ACT_MERGE, 8'd5, 8'd255, 1'b0);
        offer(ACT_MERGE, 8'd6, 8'd0, 1'b0);
        offer(ACT_MERGE, 8'd5, 8'd255, 1'b1);
        offer(ACT_MERGE, 8'd5, 8'd0, 1'b0);
        offer(ACT_CLEAR, 8'd0, 8'd0, 1'b0);

        // one slot, zero hop limit: too far wins over full
        set_config(8'd1, 8'd0, 8'd255);
        offer(ACT_CLEAR, 8'd0, 8'd0, 1'b0);
        offer(ACT_MERGE, 8'd9, 8'd1, 1'b0);
        offer(ACT_MERGE, 8'd9, 8'd0, 1'b0);
        offer(ACT_MERGE, 8'd255, 8'd0, 1'b0);
        offer(ACT_MERGE, 8'd0, 8'd0, 1'b1);

        // top bit of the write is dropped, leaving no active slots at all
        set_config(8'h80, 8'd0, 8'd1);
        offer(ACT_CLEAR, 8'd0, 8'd0, 1'b0);
        offer(ACT_MERGE, 8'd3, 8'd0, 1'b0);
        offer(ACT_MERGE, 8'd0, 8'd0, 1'b1);
        offer(ACT_MERGE, 8'd3, 8'd0, 1'b0);

        // random rounds under a spread of settings
        set_config(8'd11, 8'd3, 8'd1);
        fill_rounds(160);
        set_config(8'd4, 8'd2, 8'h11);
        fill_rounds(200);
        // full-size table while the receiver holds off for a long stretch
        set_config(8'd64, 8'd255, 8'hC8);
        hold_req = 1'b1;
        fill_rounds(260);
        // active count above the table depth saturates
        set_config(8'hFF, 8'd255, 8'h80);
        fill_rounds(200);
        set_config(8'd1, 8'd0, 8'hAA);
        fill_rounds(120);
        set_config(8'd0, 8'd5, 8'h55);
        fill_rounds(60);
        set_config(8'd30, 8'd7, 8'h7E);
        calm = 1'b1;
        fill_rounds(250);
        wait_idle();
        calm = 1'b0;
        set_config(8'd8, 8'd1, 8'h33);
        fill_rounds(280);

        // drain, then give the block a full walk to show any stray result
        wait_idle();
        repeat (TABLE_DEPTH + 10) @(posedge aclk);
        mismatches += expected_merges.size();
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial begin
        #4_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

[files.f]
src/nbtm_pkg.sv
src/nbtm_cell.sv
src/neighbor_table_merge.sv
sim/tb.sv
